// ===== hdl/f2da_pkg.sv =====
// Shared types, codes and helpers for the float to decimal text formatter.
// No dependencies; imported by every module of the block.
`default_nettype none
package f2da_pkg;

    localparam logic [1:0] CL_NUM  = 2'd0;
    localparam logic [1:0] CL_ZERO = 2'd1;
    localparam logic [1:0] CL_INF  = 2'd2;
    localparam logic [1:0] CL_NAN  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_E     = 8'h65;

    localparam logic [4:0] PREC_RESET = 5'd6;
    localparam int         OQ_DEPTH   = 4;

    typedef struct packed {
        logic        neg;
        logic [1:0]  cls;
        logic [7:0]  ex;
        logic [22:0] frac;
    } t_item;

    typedef struct packed {
        logic       we;
        logic [7:0] ch;
        logic       last;
    } t_oq_wr;

    // exact unsigned divide by ten for any 32-bit value
    function automatic logic [31:0] div10(input logic [31:0] m);
        logic [63:0] p;
        begin
            p = {32'd0, m} * 64'h0000_0000_CCCC_CCCD;
            div10 = {3'd0, p[63:35]};
        end
    endfunction

    function automatic logic [7:0] dig_char(input logic [3:0] d);
        dig_char = CH_ZERO + {4'd0, d};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/f2da_front.sv =====
// Front end: takes raw bit patterns, classifies them, and holds them in a
// two-entry queue for the back end. Depends on f2da_pkg.
`default_nettype none
module f2da_front import f2da_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_float_bits,
    output logic             o_valid,
    output t_item            o_item,
    input  wire logic        i_take
);
    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       w_in;
    logic        w_wr, w_rd;

    always_comb begin
        w_in.neg  = i_float_bits[31];
        w_in.ex   = i_float_bits[30:23];
        w_in.frac = i_float_bits[22:0];
        priority if (i_float_bits[30:23] == 8'hff)
            w_in.cls = (i_float_bits[22:0] == 23'd0) ? CL_INF : CL_NAN;
        else if (i_float_bits[30:23] == 8'h00)
            w_in.cls = CL_ZERO;
        else
            w_in.cls = CL_NUM;
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= w_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/f2da_back.sv =====
// Back end (depends on f2da_pkg): scales the mantissa, extracts and rounds
// digits; emits one character per cycle while the output queue has room.
`default_nettype none
module f2da_back import f2da_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [4:0] i_prec,
    input  wire logic       i_valid,
    input  wire t_item      i_item,
    output logic            o_take,
    input  wire logic       i_oq_full,
    output t_oq_wr          o_oq
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SIGN  = 5'd1;
    localparam logic [4:0] S_TXT   = 5'd2;
    localparam logic [4:0] S_SCALE = 5'd3;
    localparam logic [4:0] S_DIGIT = 5'd4;
    localparam logic [4:0] S_NORM  = 5'd5;
    localparam logic [4:0] S_ROUND = 5'd6;
    localparam logic [4:0] S_TRIM  = 5'd7;
    localparam logic [4:0] S_PD    = 5'd8;
    localparam logic [4:0] S_PDOT  = 5'd9;
    localparam logic [4:0] S_PZ    = 5'd10;
    localparam logic [4:0] S_N0    = 5'd11;
    localparam logic [4:0] S_NDOT  = 5'd12;
    localparam logic [4:0] S_NZ    = 5'd13;
    localparam logic [4:0] S_ND    = 5'd14;
    localparam logic [4:0] S_ED0   = 5'd15;
    localparam logic [4:0] S_EDOT  = 5'd16;
    localparam logic [4:0] S_ED    = 5'd17;
    localparam logic [4:0] S_EEX   = 5'd18;
    localparam logic [4:0] S_EM    = 5'd19;
    localparam logic [4:0] S_ET    = 5'd20;
    localparam logic [4:0] S_EU    = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;

    logic [4:0]        r_st, n_st;
    logic [31:0]       r_m, n_m;
    logic [7:0]        r_cnt, n_cnt;
    logic              r_pos, n_pos;
    logic signed [7:0] r_e10, n_e10;
    logic [3:0]        r_dig [10];
    logic [3:0]        n_dig [10];
    logic [4:0]        r_k, n_k;
    logic [3:0]        r_n, n_n;
    logic              r_neg, n_neg;
    logic [1:0]        r_cls, n_cls;
    logic [7:0]        r_hold, n_hold;
    logic              r_hold_v, n_hold_v;

    logic        adv, push_v, fin;
    logic [7:0]  push_c;
    logic [4:0]  pc;
    logic [3:0]  n9;
    logic [31:0] m1, q;
    logic [3:0]  rem, dsel, dnext;
    logic [6:0]  eabs;
    logic [14:0] tprod;
    logic [3:0]  tens, units;
    logic [3:0]  k4;

    assign adv = !r_hold_v || !i_oq_full;
    assign pc  = (i_prec == 5'd0) ? 5'd1 : ((i_prec > 5'd16) ? 5'd16 : i_prec);
    assign n9  = (pc > 5'd9) ? 4'd9 : pc[3:0];
    assign k4  = r_k[3:0];

    always_comb begin
        n_st = r_st; n_m = r_m; n_cnt = r_cnt; n_pos = r_pos; n_e10 = r_e10;
        n_dig = r_dig; n_k = r_k; n_n = r_n; n_neg = r_neg; n_cls = r_cls;
        n_hold = r_hold; n_hold_v = r_hold_v;
        push_v = 1'b0; push_c = CH_ZERO; fin = 1'b0; o_take = 1'b0;
        m1 = r_m;
        q = div10(r_m);
        rem = 4'(r_m - (q << 3) - (q << 1));
        dsel = r_dig[k4];
        dnext = dsel + 4'd1;
        eabs = r_e10[6:0];
        tprod = {8'd0, eabs} * 15'd205;
        tens = tprod[14:11];
        units = 4'(eabs - 7'({tens, 3'd0}) - 7'({tens, 1'b0}));

        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_neg = i_item.neg;
                    n_cls = i_item.cls;
                    n_m = {1'b1, i_item.frac, 8'd0};
                    n_e10 = 8'sd0;
                    n_k = 5'd0;
                    if (i_item.ex > 8'd158) begin
                        n_pos = 1'b1;
                        n_cnt = i_item.ex - 8'd158;
                    end else begin
                        n_pos = 1'b0;
                        n_cnt = 8'd158 - i_item.ex;
                    end
                    n_st = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_neg && r_cls != CL_NAN) begin
                    push_v = 1'b1; push_c = CH_MINUS;
                    if (adv) n_st = (r_cls == CL_NUM) ? S_SCALE : S_TXT;
                end else begin
                    n_st = (r_cls == CL_NUM) ? S_SCALE : S_TXT;
                end
            end
            S_TXT: begin
                push_v = 1'b1;
                unique case (r_cls)
                    CL_NAN:  push_c = (r_k == 5'd1) ? 8'h61 : 8'h4e;
                    CL_INF:  push_c = (r_k == 5'd0) ? 8'h49 :
                                      ((r_k == 5'd1) ? 8'h6e : 8'h66);
                    default: push_c = CH_ZERO;
                endcase
                if (adv) begin
                    if (r_cls == CL_ZERO || r_cls == CL_NUM || r_k == 5'd2) n_st = S_FIN;
                    else n_k = r_k + 5'd1;
                end
            end
            S_SCALE: begin
                if (r_cnt == 8'd0) begin
                    n_k = 5'd9;
                    n_st = S_DIGIT;
                end else if (r_pos) begin
                    n_cnt = r_cnt - 8'd1;
                    if (r_m[31]) begin
                        m1 = q;
                        n_e10 = r_e10 + 8'sd1;
                        if (r_cnt > 8'd2) begin
                            m1 = m1 << 2;
                            n_cnt = r_cnt - 8'd3;
                        end
                    end
                    n_m = m1 << 1;
                end else begin
                    n_cnt = r_cnt - 8'd1;
                    if (r_m < 32'h1900_0000) begin
                        m1 = (r_m << 3) + (r_m << 1);
                        n_e10 = r_e10 - 8'sd1;
                        if (r_cnt > 8'd2) begin
                            m1 = m1 >> 2;
                            n_cnt = r_cnt - 8'd3;
                        end
                    end
                    n_m = m1 >> 1;
                end
            end
            S_DIGIT: begin
                n_dig[k4] = rem;
                n_m = q;
                if (r_k == 5'd0) begin
                    n_e10 = r_e10 + 8'sd9;
                    n_st = S_NORM;
                end else begin
                    n_k = r_k - 5'd1;
                end
            end
            S_NORM: begin
                if (r_dig[0] != 4'd0) begin
                    n_n = n9;
                    n_dig[n9] = 4'd0;
                    n_k = {1'b0, n9 - 4'd1};
                    n_st = (r_dig[n9] >= 4'd5) ? S_ROUND : S_TRIM;
                end else if (r_k == 5'd9) begin
                    n_cls = CL_ZERO;
                    n_k = 5'd0;
                    n_st = S_TXT;
                end else begin
                    for (int i = 0; i < 9; i++) n_dig[i] = r_dig[i + 1];
                    n_dig[9] = 4'd0;
                    n_e10 = r_e10 - 8'sd1;
                    n_k = r_k + 5'd1;
                end
            end
            S_ROUND: begin
                if (dnext == 4'd10) begin
                    n_dig[k4] = 4'd0;
                    if (r_k == 5'd0) begin
                        for (int i = 0; i < 10; i++) n_dig[i] = 4'd0;
                        n_dig[0] = 4'd1;
                        n_e10 = r_e10 + 8'sd1;
                        n_st = S_TRIM;
                    end else begin
                        n_k = r_k - 5'd1;
                    end
                end else begin
                    n_dig[k4] = dnext;
                    n_st = S_TRIM;
                end
            end
            S_TRIM: begin
                n_k = 5'd0;
                if (r_n > 4'd1 && r_dig[r_n - 4'd1] == 4'd0) begin
                    n_n = r_n - 4'd1;
                end else if (r_e10 >= -8'sd2 && r_e10 < $signed({3'd0, pc})) begin
                    n_st = (r_e10 >= 8'sd0) ? S_PD : S_N0;
                end else begin
                    n_st = S_ED0;
                end
            end
            S_PD: begin
                push_v = 1'b1; push_c = dig_char(dsel);
                if (adv) begin
                    if ($signed({3'd0, r_k}) == r_e10 && k4 != r_n - 4'd1) begin
                        n_st = S_PDOT;
                    end else if (k4 == r_n - 4'd1) begin
                        n_k = {1'b0, r_n};
                        n_st = S_PZ;
                    end else begin
                        n_k = r_k + 5'd1;
                    end
                end
            end
            S_PDOT: begin
                push_v = 1'b1; push_c = CH_DOT;
                if (adv) begin
                    n_k = r_k + 5'd1;
                    n_st = S_PD;
                end
            end
            S_PZ: begin
                if ($signed({3'd0, r_k}) <= r_e10) begin
                    push_v = 1'b1; push_c = CH_ZERO;
                    if (adv) n_k = r_k + 5'd1;
                end else begin
                    n_st = S_FIN;
                end
            end
            S_N0: begin
                push_v = 1'b1; push_c = CH_ZERO;
                if (adv) n_st = S_NDOT;
            end
            S_NDOT: begin
                push_v = 1'b1; push_c = CH_DOT;
                if (adv) n_st = (r_e10 == -8'sd2) ? S_NZ : S_ND;
            end
            S_NZ: begin
                push_v = 1'b1; push_c = CH_ZERO;
                if (adv) n_st = S_ND;
            end
            S_ND: begin
                push_v = 1'b1; push_c = dig_char(dsel);
                if (adv) begin
                    if (k4 == r_n - 4'd1) n_st = S_FIN;
                    else n_k = r_k + 5'd1;
                end
            end
            S_ED0: begin
                push_v = 1'b1; push_c = dig_char(r_dig[0]);
                if (adv) n_st = S_EDOT;
            end
            S_EDOT: begin
                push_v = 1'b1; push_c = CH_DOT;
                if (adv) begin
                    n_k = 5'd1;
                    n_st = (r_n > 4'd1) ? S_ED : S_EEX;
                end
            end
            S_ED: begin
                push_v = 1'b1; push_c = dig_char(dsel);
                if (adv) begin
                    if (k4 == r_n - 4'd1) n_st = S_EEX;
                    else n_k = r_k + 5'd1;
                end
            end
            S_EEX: begin
                if (r_e10 == 8'sd0) begin
                    n_st = S_FIN;
                end else begin
                    push_v = 1'b1; push_c = CH_E;
                    if (adv) n_st = S_EM;
                end
            end
            S_EM: begin
                if (r_e10 < 8'sd0) begin
                    push_v = 1'b1; push_c = CH_MINUS;
                    if (adv) begin
                        n_e10 = -r_e10;
                        n_st = S_ET;
                    end
                end else begin
                    n_st = S_ET;
                end
            end
            S_ET: begin
                if (tens != 4'd0) begin
                    push_v = 1'b1; push_c = dig_char(tens);
                    if (adv) n_st = S_EU;
                end else begin
                    n_st = S_EU;
                end
            end
            S_EU: begin
                push_v = 1'b1; push_c = dig_char(units);
                if (adv) n_st = S_FIN;
            end
            S_FIN: begin
                fin = 1'b1;
                if (adv) begin
                    n_hold_v = 1'b0;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        // one-character delay so the final one can carry the last flag
        if (push_v && adv) begin
            n_hold = push_c;
            n_hold_v = 1'b1;
        end
        o_oq.we   = r_hold_v && adv && (push_v || fin);
        o_oq.ch   = r_hold;
        o_oq.last = fin;
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m; r_cnt <= n_cnt; r_pos <= n_pos; r_e10 <= n_e10;
        r_dig <= n_dig; r_k <= n_k; r_n <= n_n; r_neg <= n_neg;
        r_cls <= n_cls; r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_hold_v <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_hold_v <= n_hold_v;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/f2da_outq.sv =====
// Output queue of characters with last flags, read from the result side.
// Depends on f2da_pkg.
`default_nettype none
module f2da_outq import f2da_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_oq_wr     i_wr,
    output logic            o_full,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_character,
    output logic            o_last
);
    localparam int AW = $clog2(OQ_DEPTH);

    logic [8:0]    r_mem [OQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_rd;

    assign o_full      = (r_cnt == (AW+1)'(OQ_DEPTH));
    assign empty       = (r_cnt == '0);
    assign w_rd        = pop && !empty;
    assign o_character = r_mem[r_rp][8:1];
    assign o_last      = r_mem[r_rp][0];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[r_wp] <= {i_wr.ch, i_wr.last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.we) r_wp <= r_wp + AW'(1);
            if (w_rd)    r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_wr.we) - (AW+1)'(w_rd);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/float_to_decimal_ascii.sv =====
// Single precision to decimal text, one ASCII character per result item.
// One item is converted at a time: mantissa scaling over |exponent - 158|
// shift steps (one to three per cycle), digit extraction and rounding,
// then text at one character per cycle while the output queue has room.
// Synchronous active-low reset empties both queues and sets precision to 6.
`default_nettype none
module float_to_decimal_ascii import f2da_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_float_bits,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_character,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata
);
    logic [4:0] r_prec;
    logic       w_valid, w_take, w_oq_full;
    t_item      w_item;
    t_oq_wr     w_oq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_prec <= PREC_RESET;
        else if (i_cfg_we) r_prec <= i_cfg_wdata;
    end

    f2da_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_float_bits,
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    f2da_back u_back (
        .i_clk, .i_rst_n, .i_prec(r_prec), .i_valid(w_valid), .i_item(w_item),
        .o_take(w_take), .i_oq_full(w_oq_full), .o_oq(w_oq)
    );

    f2da_outq u_outq (
        .i_clk, .i_rst_n, .i_wr(w_oq), .o_full(w_oq_full), .empty, .pop,
        .o_character, .o_last
    );

    a_no_oq_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_oq.we |-> !w_oq_full) else $error("output queue written while full");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid) else $error("back end took from an empty queue");

    a_prec_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_prec == PREC_RESET) else $error("precision reset");
endmodule
`default_nettype wire
